### hdl/dvtu_pkg.sv
// Shared constants, types and codes for the distance-vector route table update block.
package dvtu_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int PORT_COUNT  = 4;
  localparam int LOCAL_SLOTS = 4;

  localparam int ADDR_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int LCNT_W     = 3;
  localparam int SLOT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR_3 = 3'd4;

  localparam logic [7:0] HOPS_MAX = 8'hff;

  typedef enum logic [1:0] {
    ACT_UNCHANGED = 2'd0,
    ACT_IMPROVED  = 2'd1,
    ACT_INSERTED  = 2'd2,
    ACT_FULL      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOCAL,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [7:0]  hops;
    logic [31:0] next_hop;
    logic [1:0]  port;
    logic        host_mask;
  } route_entry_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  hops;
    logic [31:0] next_hop;
    logic [1:0]  port;
    logic        host_mask;
  } result_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } local_match_t;

endpackage

### hdl/dvtu_if.sv
// Valid/ready channel interfaces for route entries in and table results out.
interface dvtu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] dest_address;
  logic [7:0]  advertised_hops;
  logic [31:0] neighbor_address;
  logic [1:0]  arrival_port;
  logic        last_entry;

  modport source (output valid, dest_address, advertised_hops, neighbor_address,
                  arrival_port, last_entry, input ready);
  modport sink (input valid, dest_address, advertised_hops, neighbor_address,
                arrival_port, last_entry, output ready);
endinterface

interface dvtu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  stored_hops;
  logic [31:0] next_hop_address;
  logic [1:0]  out_port;
  logic        host_mask;
  logic        advertise_due;

  modport source (output valid, action, stored_hops, next_hop_address, out_port,
                  host_mask, advertise_due, input ready);
  modport sink (input valid, action, stored_hops, next_hop_address, out_port,
                host_mask, advertise_due, output ready);
endinterface

### hdl/dvtu_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module dvtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/dvtu_cfg.sv
// Local interface address registers and the priority match against them.
module dvtu_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [dvtu_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [dvtu_pkg::CFG_DATA_W-1:0] wr_data,
  input  logic [31:0]                     dest,
  output dvtu_pkg::local_match_t          match
);
  import dvtu_pkg::*;

  logic [LCNT_W-1:0] local_count;
  logic [31:0]       local_addr [LOCAL_SLOTS];
  logic [LCNT_W-1:0] nloc;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_count <= '0;
      for (int i = 0; i < LOCAL_SLOTS; i++) begin
        local_addr[i] <= '0;
      end
    end else if (wr_en) begin
      case (wr_index)
        CFG_LOCAL_COUNT: local_count <= wr_data[LCNT_W-1:0];
        CFG_LOCAL_ADDR_0, CFG_LOCAL_ADDR_1, CFG_LOCAL_ADDR_2, CFG_LOCAL_ADDR_3: begin
          local_addr[SLOT_W'(wr_index - CFG_LOCAL_ADDR_0)] <= wr_data;
        end
        default: ;
      endcase
    end
  end

  assign nloc = (local_count > LCNT_W'(LOCAL_SLOTS)) ? LCNT_W'(LOCAL_SLOTS) : local_count;

  // The lowest matching slot wins.
  always_comb begin
    match = '0;
    for (int i = LOCAL_SLOTS - 1; i >= 0; i--) begin
      if ((LCNT_W'(i) < nloc) && (local_addr[i] == dest)) begin
        match.hit  = 1'b1;
        match.slot = SLOT_W'(i);
      end
    end
  end
endmodule

### hdl/dvtu_scan.sv
// Sequencer that walks the route table memory, updates or inserts, and holds the result.
module dvtu_scan (
  input  logic                                clk,
  input  logic                                rst,
  dvtu_in_if.sink                             route_in,
  dvtu_out_if.source                          route_out,
  input  dvtu_pkg::local_match_t              match,
  output logic [31:0]                         dest,
  output logic                                ram_we,
  output logic [dvtu_pkg::ADDR_W-1:0]         ram_waddr,
  output logic [$bits(dvtu_pkg::route_entry_t)-1:0] ram_wdata,
  output logic [dvtu_pkg::ADDR_W-1:0]         ram_raddr,
  input  logic [$bits(dvtu_pkg::route_entry_t)-1:0] ram_rdata
);
  import dvtu_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [7:0]        new_hops;
  logic [31:0]       nbr;
  logic [1:0]        port;
  logic              last;
  logic              port_ok;
  logic [CNT_W-1:0]  entry_count;
  logic              changed_pending;
  logic [ADDR_W-1:0] chk_idx;
  result_t           res;
  result_t           res_next;
  logic              res_changed;
  logic              res_changed_next;
  logic              count_inc;
  route_entry_t      rd_entry;
  route_entry_t      wr_entry;
  logic              dest_hit;
  logic              chk_last;
  logic              table_full;
  logic              out_free;

  assign rd_entry   = route_entry_t'(ram_rdata);
  assign ram_wdata  = wr_entry;
  assign dest_hit   = (rd_entry.dest == dest);
  assign chk_last   = ((CNT_W'(chk_idx) + CNT_W'(1)) == entry_count);
  assign table_full = (entry_count == CNT_W'(TABLE_DEPTH));
  assign out_free   = !route_out.valid || route_out.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (route_in.valid) state_next = ST_LOCAL;
      ST_LOCAL: begin
        if (match.hit || (entry_count == '0)) state_next = ST_FINISH;
        else state_next = ST_SCAN;
      end
      ST_SCAN:   if (dest_hit || chk_last) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    logic not_found;
    logic found;
    not_found        = 1'b0;
    found            = 1'b0;
    route_in.ready   = (state == ST_IDLE);
    ram_raddr        = (state == ST_LOCAL) ? '0 : ADDR_W'(chk_idx + ADDR_W'(1));
    ram_we           = 1'b0;
    ram_waddr        = chk_idx;
    wr_entry         = rd_entry;
    res_next         = res;
    res_changed_next = res_changed;
    count_inc        = 1'b0;

    case (state)
      ST_LOCAL: begin
        if (match.hit) begin
          res_next           = '0;
          res_next.action    = ACT_UNCHANGED;
          res_next.port      = match.slot;
          res_next.host_mask = 1'b1;
          res_changed_next   = 1'b0;
        end else if (entry_count == '0) begin
          not_found = 1'b1;
        end
      end
      ST_SCAN: begin
        if (dest_hit) found = 1'b1;
        else if (chk_last) not_found = 1'b1;
      end
      default: ;
    endcase

    if (found) begin
      if (port_ok && (rd_entry.hops > new_hops)) begin
        ram_we            = 1'b1;
        wr_entry.hops     = new_hops;
        wr_entry.next_hop = nbr;
        wr_entry.port     = port;
        res_next.action   = ACT_IMPROVED;
        res_changed_next  = 1'b1;
      end else begin
        res_next.action  = ACT_UNCHANGED;
        res_changed_next = 1'b0;
      end
      res_next.hops      = wr_entry.hops;
      res_next.next_hop  = wr_entry.next_hop;
      res_next.port      = wr_entry.port;
      res_next.host_mask = wr_entry.host_mask;
    end

    if (not_found) begin
      res_next         = '0;
      res_changed_next = 1'b0;
      if (port_ok) begin
        if (!table_full) begin
          ram_we             = 1'b1;
          ram_waddr          = entry_count[ADDR_W-1:0];
          wr_entry.dest      = dest;
          wr_entry.hops      = new_hops;
          wr_entry.next_hop  = nbr;
          wr_entry.port      = port;
          wr_entry.host_mask = (dest == nbr);
          count_inc          = 1'b1;
          res_next.action    = ACT_INSERTED;
          res_next.hops      = new_hops;
          res_next.next_hop  = nbr;
          res_next.port      = port;
          res_next.host_mask = wr_entry.host_mask;
          res_changed_next   = 1'b1;
        end else begin
          res_next.action = ACT_FULL;
        end
      end else begin
        res_next.action = ACT_UNCHANGED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      entry_count     <= '0;
      changed_pending <= 1'b0;
      route_out.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (count_inc) entry_count <= entry_count + CNT_W'(1);
      if (state == ST_FINISH && out_free) begin
        route_out.valid <= 1'b1;
        changed_pending <= last ? 1'b0 : (changed_pending | res_changed);
      end else if (route_out.ready) begin
        route_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && route_in.valid) begin
      dest     <= route_in.dest_address;
      new_hops <= (route_in.advertised_hops == HOPS_MAX) ? HOPS_MAX
                                                         : route_in.advertised_hops + 8'd1;
      nbr      <= route_in.neighbor_address;
      port     <= route_in.arrival_port;
      last     <= route_in.last_entry;
      port_ok  <= (32'(route_in.arrival_port) < 32'(PORT_COUNT));
    end
    if (state == ST_LOCAL) chk_idx <= '0;
    else if (state == ST_SCAN) chk_idx <= ADDR_W'(chk_idx + ADDR_W'(1));
    res         <= res_next;
    res_changed <= res_changed_next;
    if (state == ST_FINISH && out_free) begin
      route_out.action           <= res.action;
      route_out.stored_hops      <= res.hops;
      route_out.next_hop_address <= res.next_hop;
      route_out.out_port         <= res.port;
      route_out.host_mask        <= res.host_mask;
      route_out.advertise_due    <= last & (changed_pending | res_changed);
    end
  end
endmodule

### hdl/distance_vector_table_update.sv
// Top level of the distance-vector route table update block.
// A local destination or an empty table skips the table scan. Otherwise the table memory's
// read port yields one entry per cycle until the destination or the last entry is reached.
// One entry is in flight at a time; the next is taken once the previous result is registered.
// Reset clears the control state, the local address registers and the entry count; the
// table memory is not cleared, since only entries below the count are ever used.
module distance_vector_table_update (
  input  logic                            clk,
  input  logic                            rst,
  dvtu_in_if.sink                         route_in,
  dvtu_out_if.source                      route_out,
  input  logic                            wr_en,
  input  logic [dvtu_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [dvtu_pkg::CFG_DATA_W-1:0] wr_data
);
  import dvtu_pkg::*;

  local_match_t                     match;
  logic [31:0]                      dest;
  logic                             ram_we;
  logic [ADDR_W-1:0]                ram_waddr;
  logic [$bits(route_entry_t)-1:0]  ram_wdata;
  logic [ADDR_W-1:0]                ram_raddr;
  logic [$bits(route_entry_t)-1:0]  ram_rdata;

  dvtu_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .dest     (dest),
    .match    (match)
  );

  dvtu_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .route_in  (route_in),
    .route_out (route_out),
    .match     (match),
    .dest      (dest),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  dvtu_ram #(
    .WIDTH ($bits(route_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
endmodule

### hdl/dvtu_checker.sv
// Port-level checker for the route table update block and its bind.
module dvtu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  action,
  input logic [7:0]  stored_hops,
  input logic [31:0] next_hop_address,
  input logic [1:0]  out_port,
  input logic        host_mask
);
  import dvtu_pkg::*;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Input taken while an entry is still in flight.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(action) && $stable(stored_hops)))
    else $error("Stalled result beat changed.");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == ACT_FULL) |->
      (stored_hops == '0 && next_hop_address == '0 && out_port == '0 && host_mask == 1'b0))
    else $error("Dropped entry reports a held route.");

  a_new_hops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action == ACT_INSERTED || action == ACT_IMPROVED)) |-> (stored_hops != '0))
    else $error("Changed route carries a zero hop count.");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result beat shown right after reset.");
endmodule

bind distance_vector_table_update dvtu_checker u_dvtu_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (route_in.valid),
  .in_ready         (route_in.ready),
  .out_valid        (route_out.valid),
  .out_ready        (route_out.ready),
  .action           (route_out.action),
  .stored_hops      (route_out.stored_hops),
  .next_hop_address (route_out.next_hop_address),
  .out_port         (route_out.out_port),
  .host_mask        (route_out.host_mask)
);

### tb/tb.sv
// Self-checking testbench for the distance-vector route table update block.
module tb;
  import dvtu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int PAUSE_MAX = 17;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int PHASES = 7;

  typedef struct packed {
    logic [31:0] dest;
    logic [7:0]  hops;
    logic [31:0] neighbor;
    logic [1:0]  port;
    logic        last;
  } advert_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  hops;
    logic [31:0] next_hop;
    logic [1:0]  port;
    logic        host_mask;
    logic        due;
  } route_reply_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  dvtu_in_if  route_in();
  dvtu_out_if route_out();

  distance_vector_table_update i_dut (
    .clk(clk),
    .rst(rst),
    .route_in(route_in),
    .route_out(route_out),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  logic [LCNT_W-1:0] rt_local_count;
  logic [31:0] rt_local_addr [LOCAL_SLOTS];
  route_entry_t model_routes [TABLE_DEPTH];
  int rt_entries = 0;
  logic rt_change_seen = 1'b0;

  advert_t queued_adverts[$];
  route_reply_t awaited_replies[$];
  advert_t on_wire;
  int queued_count = 0;
  int accepted_count = 0;
  int result_count = 0;
  int fault_count = 0;
  int in_hold;
  int out_hold;
  int unsigned cycle_count = 0;
  logic in_calm;
  logic out_calm;
  logic [31:0] phase_counts [PHASES] = '{32'd7, 32'd0, 32'd2, 32'hffff_fffd, 32'd4, 32'd1,
                                        32'd3};

  assign in_calm = ((cycle_count / 400) % 3) == 0;
  assign out_calm = ((cycle_count / 700) % 3) == 1;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic route_reply_t apply_advert(advert_t a);
    route_reply_t r;
    logic [8:0] sum;
    logic [7:0] new_hops;
    int nloc;
    int i;
    logic found;
    logic changed;
    r = '0;
    found = 1'b0;
    changed = 1'b0;
    sum = {1'b0, a.hops} + 9'd1;
    new_hops = sum[8] ? HOPS_MAX : sum[7:0];
    nloc = (rt_local_count > LOCAL_SLOTS) ? LOCAL_SLOTS : int'(rt_local_count);
    for (i = 0; i < nloc && !found; i++) begin
      if (rt_local_addr[i] == a.dest) begin
        found = 1'b1;
        r.port = 2'(i);
        r.host_mask = 1'b1;
      end
    end
    for (i = 0; i < rt_entries && !found; i++) begin
      if (model_routes[i].dest == a.dest) begin
        found = 1'b1;
        if (a.port < PORT_COUNT && model_routes[i].hops > new_hops) begin
          model_routes[i].hops = new_hops;
          model_routes[i].next_hop = a.neighbor;
          model_routes[i].port = a.port;
          r.action = ACT_IMPROVED;
          changed = 1'b1;
        end
        r.hops = model_routes[i].hops;
        r.next_hop = model_routes[i].next_hop;
        r.port = model_routes[i].port;
        r.host_mask = model_routes[i].host_mask;
      end
    end
    if (!found && a.port < PORT_COUNT) begin
      if (rt_entries < TABLE_DEPTH) begin
        model_routes[rt_entries].dest = a.dest;
        model_routes[rt_entries].hops = new_hops;
        model_routes[rt_entries].next_hop = a.neighbor;
        model_routes[rt_entries].port = a.port;
        model_routes[rt_entries].host_mask = (a.dest == a.neighbor);
        r.hops = new_hops;
        r.next_hop = a.neighbor;
        r.port = a.port;
        r.host_mask = model_routes[rt_entries].host_mask;
        r.action = ACT_INSERTED;
        rt_entries++;
        changed = 1'b1;
      end else begin
        r.action = ACT_FULL;
      end
    end
    r.due = a.last && (rt_change_seen || changed);
    rt_change_seen = a.last ? 1'b0 : (rt_change_seen || changed);
    return r;
  endfunction

  function automatic string reply_str(route_reply_t r);
    return $sformatf("action=%0d hops=%0d next_hop=%h port=%0d host_mask=%b due=%b",
                     r.action, r.hops, r.next_hop, r.port, r.host_mask, r.due);
  endfunction

  function automatic int draw_pause(logic calm);
    return calm ? 0 : $urandom_range(0, PAUSE_MAX);
  endfunction

  task automatic queue_advert(logic [31:0] d, logic [7:0] h, logic [31:0] n, logic [1:0] p,
                              logic l);
    advert_t a;
    a.dest = d;
    a.hops = h;
    a.neighbor = n;
    a.port = p;
    a.last = l;
    queued_adverts.insert(queued_adverts.size(), a);
    queued_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    if (idx == CFG_LOCAL_COUNT)
      rt_local_count = data[LCNT_W-1:0];
    else
      rt_local_addr[idx - CFG_LOCAL_ADDR_0] = data;
  endtask

  task automatic set_locals(logic [31:0] count, logic [31:0] a0, logic [31:0] a1,
                            logic [31:0] a2, logic [31:0] a3);
    write_reg(CFG_LOCAL_COUNT, count);
    write_reg(CFG_LOCAL_ADDR_0, a0);
    write_reg(CFG_LOCAL_ADDR_1, a1);
    write_reg(CFG_LOCAL_ADDR_2, a2);
    write_reg(CFG_LOCAL_ADDR_3, a3);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (accepted_count != queued_count || awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    advert_t nxt;
    if (rst) begin
      route_in.valid <= 1'b0;
      route_in.dest_address <= '0;
      route_in.advertised_hops <= '0;
      route_in.neighbor_address <= '0;
      route_in.arrival_port <= '0;
      route_in.last_entry <= 1'b0;
      in_hold <= 0;
    end else begin
      if (route_in.valid && route_in.ready) begin
        awaited_replies.insert(awaited_replies.size(), apply_advert(on_wire));
        accepted_count++;
      end
      if (!route_in.valid || route_in.ready) begin
        if (in_hold != 0) begin
          in_hold <= in_hold - 1;
          route_in.valid <= 1'b0;
        end else if (queued_adverts.size() != 0) begin
          nxt = queued_adverts.pop_front();
          on_wire <= nxt;
          route_in.dest_address <= nxt.dest;
          route_in.advertised_hops <= nxt.hops;
          route_in.neighbor_address <= nxt.neighbor;
          route_in.arrival_port <= nxt.port;
          route_in.last_entry <= nxt.last;
          route_in.valid <= 1'b1;
          in_hold <= draw_pause(in_calm);
        end else begin
          route_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    route_reply_t seen;
    route_reply_t want;
    int pause;
    if (rst) begin
      route_out.ready <= 1'b0;
      out_hold <= 0;
    end else if (route_out.valid && route_out.ready) begin
      seen.action = action_t'(route_out.action);
      seen.hops = route_out.stored_hops;
      seen.next_hop = route_out.next_hop_address;
      seen.port = route_out.out_port;
      seen.host_mask = route_out.host_mask;
      seen.due = route_out.advertise_due;
      if (awaited_replies.size() == 0) begin
        if (fault_count < 10)
          $display("ERROR: unexpected route result: %s", reply_str(seen));
        fault_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (seen !== want) begin
          if (fault_count < 10)
            $display("ERROR: route result %0d: expected %s, got %s", result_count,
                     reply_str(want), reply_str(seen));
          fault_count++;
        end
      end
      result_count++;
      pause = draw_pause(out_calm);
      route_out.ready <= (pause == 0);
      out_hold <= pause;
    end else if (out_hold != 0) begin
      route_out.ready <= (out_hold == 1);
      out_hold <= out_hold - 1;
    end else begin
      route_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: timeout with %0d results outstanding", awaited_replies.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int phase;
    int k;
    int j;
    int plen;
    int sel;
    logic [31:0] d;
    logic [31:0] n;
    logic [7:0] h;
    logic [31:0] a [LOCAL_SLOTS];
    logic [31:0] known[$];
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= CFG_LOCAL_COUNT;
    wr_data <= '0;
    rt_local_count = '0;
    for (j = 0; j < LOCAL_SLOTS; j++) rt_local_addr[j] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    queue_advert(32'h0000_0000, 8'h00, 32'h0000_0000, 2'd0, 1'b0);
    queue_advert(32'hffff_ffff, 8'hff, 32'hffff_ffff, 2'd3, 1'b1);
    queue_advert(32'hffff_ffff, 8'hfe, 32'h1234_5678, 2'd1, 1'b1);
    queue_advert(32'h0000_0000, 8'hff, 32'h8765_4321, 2'd2, 1'b0);
    queue_advert(32'h0a00_0001, 8'h0a, 32'h0a00_0002, 2'd2, 1'b0);
    queue_advert(32'h0a00_0001, 8'h03, 32'hc0a8_0001, 2'd1, 1'b0);
    queue_advert(32'h0a00_0001, 8'h03, 32'h0a00_0001, 2'd3, 1'b1);
    queue_advert(32'h0a00_0001, 8'h00, 32'h0a00_0009, 2'd0, 1'b1);
    queue_advert(32'hffff_ffff, 8'h00, 32'h0000_0001, 2'd2, 1'b1);
    drain();

    set_locals(32'd4, 32'h0a00_0001, 32'h0000_0000, 32'hffff_ffff, 32'h0a00_0001);
    queue_advert(32'h0a00_0001, 8'h05, 32'h5555_5555, 2'd1, 1'b0);
    queue_advert(32'h0000_0000, 8'h00, 32'haaaa_aaaa, 2'd2, 1'b0);
    queue_advert(32'hffff_ffff, 8'h01, 32'hffff_ffff, 2'd3, 1'b0);
    queue_advert(32'hc0a8_0101, 8'h07, 32'hc0a8_0101, 2'd2, 1'b1);
    drain();

    set_locals(32'd1, 32'h0a00_0001, 32'h0000_0000, 32'hffff_ffff, 32'hc0a8_0101);
    queue_advert(32'h0000_0000, 8'hff, 32'h0000_0005, 2'd1, 1'b0);
    queue_advert(32'hc0a8_0101, 8'h00, 32'h0000_0007, 2'd3, 1'b1);
    queue_advert(32'h0a00_0001, 8'h02, 32'h0a00_0003, 2'd0, 1'b1);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      for (j = 0; j < LOCAL_SLOTS; j++)
        a[j] = ($urandom_range(0, 1) == 1 && rt_entries != 0) ?
               model_routes[$urandom_range(0, rt_entries - 1)].dest : $urandom();
      if (phase == 0) begin
        a[1] = a[0];
        a[3] = 32'hffff_ffff;
      end
      set_locals(phase_counts[phase], a[0], a[1], a[2], a[3]);
      for (k = 0; k < ITEMS_PER_PHASE; k += plen) begin
        plen = $urandom_range(1, 6);
        for (j = 0; j < plen; j++) begin
          sel = $urandom_range(0, 99);
          if (sel < 12) begin
            d = rt_local_addr[$urandom_range(0, LOCAL_SLOTS - 1)];
          end else if (sel < 52 && rt_entries != 0) begin
            d = model_routes[$urandom_range(0, rt_entries - 1)].dest;
          end else if (sel < 67 && known.size() != 0) begin
            d = known[$urandom_range(0, known.size() - 1)];
          end else begin
            if (sel >= 95)
              d = sel[0] ? 32'h00ff_ffff : 32'hffff_ff00;
            else
              d = $urandom();
            known.insert(known.size(), d);
          end
          n = ($urandom_range(0, 3) == 0) ? d : $urandom();
          sel = $urandom_range(0, 99);
          if (sel < 30)
            h = 8'($urandom_range(0, 15));
          else if (sel < 45)
            h = 8'($urandom_range(254, 255));
          else
            h = 8'($urandom_range(0, 255));
          queue_advert(d, h, n, 2'($urandom_range(0, 3)), j == plen - 1);
        end
      end
      drain();
    end

    if (fault_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
